// File: rtl/core/yjkdec_pkg.sv
// ----------------------------------------------------------------------------
// yjkdec_pkg
// Shared types, codes and component expansion tables for the YJK/YAE/direct
// color pixel-group decoder.
// ----------------------------------------------------------------------------
package yjkdec_pkg;

  localparam int unsigned Lanes     = 4;
  localparam int unsigned PalDepth  = 16;
  localparam int unsigned PalAddrW  = $clog2(PalDepth);
  localparam int unsigned PalEntryW = 9;
  localparam int unsigned RgbW      = 24;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  // Command codes carried by the input channel.
  localparam logic CmdPixel   = 1'b0;
  localparam logic CmdPalette = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic RegYjk = 1'b0;
  localparam logic RegYae = 1'b1;

  typedef struct packed {
    logic yjk;
    logic yae;
  } mode_t;

  // (c*255+3)/7
  function automatic logic [7:0] widen3(input logic [2:0] c);
    logic [7:0] v;
    case (c)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd36;
      3'd2:    v = 8'd73;
      3'd3:    v = 8'd109;
      3'd4:    v = 8'd146;
      3'd5:    v = 8'd182;
      3'd6:    v = 8'd219;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // (c*255+1)/3
  function automatic logic [7:0] widen2(input logic [1:0] c);
    logic [7:0] v;
    case (c)
      2'd0:    v = 8'd0;
      2'd1:    v = 8'd85;
      2'd2:    v = 8'd170;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // (c*255+15)/31
  function automatic logic [7:0] widen5(input logic [4:0] c);
    logic [7:0] v;
    case (c)
      5'd0:    v = 8'd0;
      5'd1:    v = 8'd8;
      5'd2:    v = 8'd16;
      5'd3:    v = 8'd25;
      5'd4:    v = 8'd33;
      5'd5:    v = 8'd41;
      5'd6:    v = 8'd49;
      5'd7:    v = 8'd58;
      5'd8:    v = 8'd66;
      5'd9:    v = 8'd74;
      5'd10:   v = 8'd82;
      5'd11:   v = 8'd90;
      5'd12:   v = 8'd99;
      5'd13:   v = 8'd107;
      5'd14:   v = 8'd115;
      5'd15:   v = 8'd123;
      5'd16:   v = 8'd132;
      5'd17:   v = 8'd140;
      5'd18:   v = 8'd148;
      5'd19:   v = 8'd156;
      5'd20:   v = 8'd165;
      5'd21:   v = 8'd173;
      5'd22:   v = 8'd181;
      5'd23:   v = 8'd189;
      5'd24:   v = 8'd197;
      5'd25:   v = 8'd206;
      5'd26:   v = 8'd214;
      5'd27:   v = 8'd222;
      5'd28:   v = 8'd230;
      5'd29:   v = 8'd239;
      5'd30:   v = 8'd247;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] clamp5(input logic signed [7:0] v);
    logic [4:0] r;
    if (v < 0) begin
      r = 5'd0;
    end else if (v > 8'sd31) begin
      r = 5'd31;
    end else begin
      r = v[4:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/yjk_yae_direct_color_decode.sv
// ----------------------------------------------------------------------------
// yjk_yae_direct_color_decode
// Pixel-group color decoder: four bitmap bytes in, four RGB pixels out.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel carries a command. A pixel
// command (cmd 0) carries four bitmap bytes and yields one output transfer
// with four packed 24-bit RGB pixels. A palette command (cmd 1) writes one
// of the 16 palette entries and yields no output transfer.
// The yjk_enable and yae_enable registers sit on the APB port at byte
// addresses 0 and 4 and should be written only while the block is idle.
// An accepted pixel group is held in the first stage (bytes and palette
// reads), then moves to the output register, from which it can leave.
// Throughput is one group per cycle while the receiver is ready; the palette
// is read at acceptance into a read register, and the color math runs
// between that stage and the output register.
// When the receiver stalls, the output register holds its result, the first
// stage fills, and in_ready_o drops only once both stages are occupied.
// Reset clears both registers, empties the pipeline and marks every palette
// entry as unwritten, so that it reads as black; no clearing pass is needed.
// ----------------------------------------------------------------------------
module yjk_yae_direct_color_decode
  import yjkdec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [7:0]          byte0_i,
  input  logic [7:0]          byte1_i,
  input  logic [7:0]          byte2_i,
  input  logic [7:0]          byte3_i,
  input  logic [PalAddrW-1:0] pal_index_i,
  input  logic [2:0]          pal_red_i,
  input  logic [2:0]          pal_green_i,
  input  logic [2:0]          pal_blue_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RgbW-1:0]     rgb0_o,
  output logic [RgbW-1:0]     rgb1_o,
  output logic [RgbW-1:0]     rgb2_o,
  output logic [RgbW-1:0]     rgb3_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  mode_t                mode_q;
  logic                 cfg_wr;

  logic                 out_free;
  logic                 in_acc;
  logic                 pal_wr;
  logic                 s1_vld_q, s1_vld_d;
  logic                 out_vld_q, out_vld_d;

  logic [7:0]           in_bytes  [Lanes];
  logic [7:0]           pix_q     [Lanes];
  logic [PalDepth-1:0]  pal_vld_q;
  logic [PalEntryW-1:0] pal_rd_q  [Lanes];
  logic                 pal_hit_q [Lanes];
  logic [PalEntryW-1:0] pal_entry [Lanes];
  logic [PalEntryW-1:0] pal_wdata;

  logic signed [5:0]    j_val;
  logic signed [5:0]    k_val;
  logic [RgbW-1:0]      rgb_d     [Lanes];
  logic [RgbW-1:0]      rgb_q     [Lanes];

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegYjk:  mode_q.yjk <= pwdata[0];
        RegYae:  mode_q.yae <= pwdata[0];
        default: mode_q     <= mode_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegYjk:  prdata = {{(ApbDataW-1){1'b0}}, mode_q.yjk};
      RegYae:  prdata = {{(ApbDataW-1){1'b0}}, mode_q.yae};
      default: prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: first stage (bytes and palette reads), output register
  // --------------------------------------------------------------------------
  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = !s1_vld_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pal_wr     = in_acc && (cmd_i == CmdPalette);

  always_comb begin
    s1_vld_d  = s1_vld_q;
    out_vld_d = out_vld_q;
    if (in_ready_o) begin
      s1_vld_d = in_acc && (cmd_i == CmdPixel);
    end
    if (out_free) begin
      out_vld_d = s1_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // --------------------------------------------------------------------------
  // Palette: one replica per lane so that each is read at a single address.
  // An entry whose valid bit is clear has not been written since reset.
  // --------------------------------------------------------------------------
  assign in_bytes[0] = byte0_i;
  assign in_bytes[1] = byte1_i;
  assign in_bytes[2] = byte2_i;
  assign in_bytes[3] = byte3_i;
  assign pal_wdata   = {pal_red_i, pal_green_i, pal_blue_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
    end else if (pal_wr) begin
      pal_vld_q[pal_index_i] <= 1'b1;
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    logic [PalEntryW-1:0] pal_mem [PalDepth];

    always_ff @(posedge clk_i) begin
      if (pal_wr) begin
        pal_mem[pal_index_i] <= pal_wdata;
      end
      if (in_acc) begin
        pal_rd_q[l]  <= pal_mem[in_bytes[l][7:4]];
        pal_hit_q[l] <= pal_vld_q[in_bytes[l][7:4]];
      end
      if (in_acc && (cmd_i == CmdPixel)) begin
        pix_q[l] <= in_bytes[l];
      end
      if (s1_vld_q && out_free) begin
        rgb_q[l] <= rgb_d[l];
      end
    end

    assign pal_entry[l] = pal_hit_q[l] ? pal_rd_q[l] : '0;

    yjkdec_lane u_lane (
      .pix_i       (pix_q[l]),
      .j_i         (j_val),
      .k_i         (k_val),
      .mode_i      (mode_q),
      .pal_entry_i (pal_entry[l]),
      .rgb_o       (rgb_d[l])
    );
  end

  // J and K are shared by the whole group: low bits first, high bits second.
  assign j_val = $signed({pix_q[1][2:0], pix_q[0][2:0]});
  assign k_val = $signed({pix_q[3][2:0], pix_q[2][2:0]});

  assign out_valid_o = out_vld_q;
  assign rgb0_o      = rgb_q[0];
  assign rgb1_o      = rgb_q[1];
  assign rgb2_o      = rgb_q[2];
  assign rgb3_o      = rgb_q[3];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pal_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_wr |=> !s1_vld_q)
    else $error("palette write entered the result pipeline");

  a_pixel_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == CmdPixel)) |=> s1_vld_q)
    else $error("accepted pixel group was lost");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  a_pal_vld_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pal_vld_q != $past(pal_vld_q)) |-> $past(pal_wr))
    else $error("palette valid bits changed without a palette write");

endmodule

// File: rtl/core/yjkdec_lane.sv
// ----------------------------------------------------------------------------
// yjkdec_lane
// Decodes one pixel byte of a group into a packed 24-bit RGB color, in
// direct GRB332, YJK or YJK with palette attribute mode.
// ----------------------------------------------------------------------------
module yjkdec_lane
  import yjkdec_pkg::*;
(
  input  logic [7:0]           pix_i,
  input  logic signed [5:0]    j_i,
  input  logic signed [5:0]    k_i,
  input  mode_t                mode_i,
  input  logic [PalEntryW-1:0] pal_entry_i,
  output logic [RgbW-1:0]      rgb_o
);

  logic [4:0]        y;
  logic signed [7:0] r_sum;
  logic signed [7:0] g_sum;
  logic signed [9:0] b_num;

  always_comb begin
    y     = pix_i[7:3];
    r_sum = $signed({3'b000, y}) + $signed({{2{j_i[5]}}, j_i});
    g_sum = $signed({3'b000, y}) + $signed({{2{k_i[5]}}, k_i});
    b_num = $signed({3'b000, y, 2'b00}) + $signed({5'b00000, y})
          - $signed({{3{j_i[5]}}, j_i, 1'b0}) - $signed({{4{k_i[5]}}, k_i});

    if (!mode_i.yjk) begin
      rgb_o = {widen3(pix_i[4:2]), widen3(pix_i[7:5]), widen2(pix_i[1:0])};
    end else if (mode_i.yae && pix_i[3]) begin
      rgb_o = {widen3(pal_entry_i[8:6]), widen3(pal_entry_i[5:3]),
               widen3(pal_entry_i[2:0])};
    end else begin
      // A negative blue numerator floors to a negative value, which clamps
      // to zero just as the truncated quotient would.
      rgb_o = {widen5(clamp5(r_sum)), widen5(clamp5(g_sum)),
               widen5(clamp5($signed(b_num[9:2])))};
    end
  end

endmodule

// File: tb/yjk_yae_direct_color_decode_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yjk_yae_direct_color_decode_tb
// Self-checking bench for the pixel-group color decoder. A directed table
// covers the direct, YJK and YAE modes and their corners. Random groups and
// palette writes then run under every mode setting and several flow-control
// profiles, including one long output stall. Each output transfer is checked
// against the table's own value or a predictor with its own palette and mode copy.
// ----------------------------------------------------------------------------
module yjk_yae_direct_color_decode_tb;
  import yjkdec_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int PhaseItems  = 210;
  localparam int HoldOffLen  = 300;

  typedef logic [3:0][RgbW-1:0] group_t;

  // bytes[0] is byte0; a 32-bit literal reads as {byte3, byte2, byte1, byte0}.
  typedef struct packed {
    logic            yjk;
    logic            yae;
    logic            cmd;
    logic [3:0][7:0] bytes;
    logic [3:0]      idx;
    logic [2:0]      red;
    logic [2:0]      green;
    logic [2:0]      blue;
    logic            typed_exp;
    group_t          want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [RgbW-1:0]     rgb0_o, rgb1_o, rgb2_o, rgb3_o;
  logic                psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata, prdata;
  logic                pready;

  row_t   drv;
  group_t groups_due [$];
  logic [8:0] pal_copy [PalDepth];
  logic   mode_yjk, mode_yae;
  int     mismatches;
  int     quiet_cycles;
  int     send_idle_pct, recv_idle_pct;
  int     hold_cycles;

  yjk_yae_direct_color_decode u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (drv.cmd),
    .byte0_i     (drv.bytes[0]),
    .byte1_i     (drv.bytes[1]),
    .byte2_i     (drv.bytes[2]),
    .byte3_i     (drv.bytes[3]),
    .pal_index_i (drv.idx),
    .pal_red_i   (drv.red),
    .pal_green_i (drv.green),
    .pal_blue_i  (drv.blue),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rgb0_o      (rgb0_o),
    .rgb1_o      (rgb1_o),
    .rgb2_o      (rgb2_o),
    .rgb3_o      (rgb3_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Expands a component of full scale maxv to 8 bits with rounding.
  function automatic logic [7:0] grow(input int c, input int maxv);
    return 8'((c * 255 + maxv / 2) / maxv);
  endfunction

  function automatic int clip31(input int v);
    return (v < 0) ? 0 : ((v > 31) ? 31 : v);
  endfunction

  function automatic group_t decode_group(input logic [3:0][7:0] px);
    group_t          g;
    logic signed [5:0] j6, k6;
    logic [8:0]      e;
    int              j, k, y, n;
    j6 = {px[1][2:0], px[0][2:0]};
    k6 = {px[3][2:0], px[2][2:0]};
    j  = int'(j6);
    k  = int'(k6);
    for (n = 0; n < 4; n++) begin
      y = int'(px[n][7:3]);
      e = pal_copy[px[n][7:4]];
      if (!mode_yjk) begin
        g[n] = {grow(int'(px[n][4:2]), 7), grow(int'(px[n][7:5]), 7),
                grow(int'(px[n][1:0]), 3)};
      end else if (mode_yae && px[n][3]) begin
        g[n] = {grow(int'(e[8:6]), 7), grow(int'(e[5:3]), 7), grow(int'(e[2:0]), 7)};
      end else begin
        g[n] = {grow(clip31(y + j), 31), grow(clip31(y + k), 31),
                grow(clip31((5 * y - 2 * j - k) / 4), 31)};
      end
    end
    return g;
  endfunction

  function automatic row_t table_row(input logic yjk, input logic yae, input logic cmd,
                                     input logic [31:0] bytes, input logic [3:0] idx,
                                     input logic [2:0] red, input logic [2:0] green,
                                     input logic [2:0] blue, input logic typed_exp,
                                     input logic [RgbW-1:0] want_px);
    row_t r;
    r.yjk       = yjk;
    r.yae       = yae;
    r.cmd       = cmd;
    r.bytes     = bytes;
    r.idx       = idx;
    r.red       = red;
    r.green     = green;
    r.blue      = blue;
    r.typed_exp = typed_exp;
    r.want      = {4{want_px}};
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatches < 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
    mismatches++;
  endtask

  // Result check, prediction at input acceptance and the stall watchdog.
  always @(posedge clk_i) begin
    group_t got, want;
    int     n;
    if (rst_ni) begin
      got = {rgb3_o, rgb2_o, rgb1_o, rgb0_o};
      if (out_valid_o && out_ready_i) begin
        if (groups_due.size() == 0) begin
          flag_mismatch("output with no group pending", '0, {8'h00, got[0]});
        end else begin
          want = groups_due.pop_front();
          for (n = 0; n < 4; n++) begin
            if (got[n] !== want[n]) begin
              flag_mismatch($sformatf("rgb%0d", n), {8'h00, want[n]}, {8'h00, got[n]});
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (drv.cmd == CmdPalette) begin
          pal_copy[drv.idx] = {drv.red, drv.green, drv.blue};
        end else begin
          groups_due.push_back(drv.typed_exp ? drv.want : decode_group(drv.bytes));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver side: random back-pressure, or a counted hold-off when requested.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One APB transfer followed by an idle bus with psel low; starts and ends at a falling edge.
  task automatic apb_access(input logic wr, input logic idx, input logic [ApbDataW-1:0] wd,
                            output logic [ApbDataW-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= wd;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits for the pipeline to drain, then writes and reads back both mode bits.
  task automatic set_mode(input logic yjk, input logic yae);
    logic [ApbDataW-1:0] wd, rd;
    int                  r;
    in_valid_i <= 1'b0;
    while (groups_due.size() != 0) @(posedge clk_i);
    // A trailing palette write leaves no result behind, so give it time to retire.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    wd = $urandom;
    wd[0] = yjk;
    apb_access(1'b1, RegYjk, wd, rd);
    wd = $urandom;
    wd[0] = yae;
    apb_access(1'b1, RegYae, wd, rd);
    mode_yjk = yjk;
    mode_yae = yae;
    for (r = 0; r < 2; r++) begin
      apb_access(1'b0, r[0], '0, rd);
      if (rd[0] !== (r[0] ? yae : yjk)) begin
        flag_mismatch($sformatf("mode register %0d", r), {31'b0, r[0] ? yae : yjk}, rd);
      end
    end
  endtask

  // Offers one item; entered at a falling edge and left at the falling edge
  // after its transfer, with valid still high.
  task automatic send_item(input row_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    drv        <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  initial begin
    row_t rows [$];
    row_t it;
    int   i, ph;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    drv           = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mode_yjk      = 1'b0;
    mode_yae      = 1'b0;
    mismatches    = 0;
    quiet_cycles  = 0;
    hold_cycles   = 0;
    send_idle_pct = 29;
    recv_idle_pct = 52;
    for (i = 0; i < PalDepth; i++) pal_copy[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Direct color extremes, palette loads, YAE without YJK, J and K at their
    // signed limits, blue clamped from below, then palette lookups.
    rows.push_back(table_row(0, 0, CmdPixel,   32'h00000000, 4'd0,  3'd0, 3'd0, 3'd0, 1, '0));
    rows.push_back(table_row(0, 0, CmdPixel,   32'hFFFFFFFF, 4'd15, 3'd7, 3'd7, 3'd7, 1,
                             24'hFFFFFF));
    rows.push_back(table_row(0, 0, CmdPixel,   32'hA503E01C, 4'd9,  3'd2, 3'd5, 3'd1, 0, '0));
    rows.push_back(table_row(0, 0, CmdPalette, 32'h12345678, 4'd15, 3'd7, 3'd7, 3'd7, 0, '0));
    rows.push_back(table_row(0, 0, CmdPalette, 32'hFFFFFFFF, 4'd0,  3'd5, 3'd2, 3'd3, 0, '0));
    rows.push_back(table_row(0, 1, CmdPixel,   32'h8818F808, 4'd3,  3'd6, 3'd0, 3'd4, 0, '0));
    rows.push_back(table_row(1, 0, CmdPixel,   32'h00000000, 4'd0,  3'd0, 3'd0, 3'd0, 1, '0));
    rows.push_back(table_row(1, 0, CmdPixel,   32'hF8F8F8F8, 4'd0,  3'd0, 3'd0, 3'd0, 1,
                             24'hFFFFFF));
    rows.push_back(table_row(1, 0, CmdPixel,   32'h44F01387, 4'd5,  3'd1, 3'd1, 3'd1, 0, '0));
    rows.push_back(table_row(1, 0, CmdPixel,   32'h3BC7FC00, 4'd0,  3'd0, 3'd0, 3'd0, 0, '0));
    rows.push_back(table_row(1, 0, CmdPixel,   32'h7F3FBFFF, 4'd0,  3'd0, 3'd0, 3'd0, 0, '0));
    rows.push_back(table_row(1, 0, CmdPixel,   32'h03070307, 4'd0,  3'd0, 3'd0, 3'd0, 0, '0));
    rows.push_back(table_row(1, 1, CmdPixel,   32'h007808F8, 4'd0,  3'd0, 3'd0, 3'd0, 0, '0));
    rows.push_back(table_row(1, 1, CmdPalette, 32'h00000000, 4'd7,  3'd1, 3'd6, 3'd4, 0, '0));
    rows.push_back(table_row(1, 1, CmdPixel,   32'h07777F7F, 4'd12, 3'd3, 3'd3, 3'd3, 0, '0));
    rows.push_back(table_row(1, 1, CmdPixel,   32'hFFFFFFFF, 4'd0,  3'd0, 3'd0, 3'd0, 1,
                             24'hFFFFFF));
    rows.push_back(table_row(1, 1, CmdPalette, 32'hFFFFFFFF, 4'd3,  3'd0, 3'd0, 3'd0, 0, '0));
    rows.push_back(table_row(1, 1, CmdPixel,   32'h38183828, 4'd0,  3'd0, 3'd0, 3'd0, 0, '0));

    set_mode(1'b0, 1'b0);
    for (i = 0; i < rows.size(); i++) begin
      if ({rows[i].yjk, rows[i].yae} != {mode_yjk, mode_yae}) begin
        set_mode(rows[i].yjk, rows[i].yae);
      end
      send_item(rows[i]);
    end

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_mode(1'b1, 1'b0);
        1: set_mode(1'b1, 1'b1);
        2: set_mode(1'b0, 1'b1);
        3: set_mode(1'b1, 1'b1);
        4: set_mode(1'b0, 1'b0);
        default: set_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
      endcase
      case (ph / 2)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // Stall the output long enough for the pipeline to fill and block input.
      if (ph == 1) hold_cycles = HoldOffLen;
      for (i = 0; i < PhaseItems; i++) begin
        it           = '0;
        it.cmd       = ($urandom_range(99) < 20) ? CmdPalette : CmdPixel;
        it.bytes     = $urandom;
        it.idx       = 4'($urandom_range(15));
        it.red       = 3'($urandom_range(7));
        it.green     = 3'($urandom_range(7));
        it.blue      = 3'($urandom_range(7));
        send_item(it);
      end
    end

    in_valid_i <= 1'b0;
    while (groups_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/yjkdec_pkg.sv
rtl/core/yjkdec_lane.sv
rtl/core/yjk_yae_direct_color_decode.sv
tb/yjk_yae_direct_color_decode_tb.sv
